// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lss_pkg.sv -----
// shared types and constants of the lifo stack with search
package lss_pkg;

    // storage and field widths
    localparam int LSS_DEPTH = 64;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 7;
    localparam int STAT_W    = 2;
    localparam int KIND_W    = 2;
    localparam int OUT_PAD_W = 7;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    // one result word
    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  value_out;
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          entry_count;
        logic                      is_empty;
        logic signed [WORD_W-1:0]  top_word;
        logic                      last;
    } res_t;

endpackage

// ----- rtl/lss_core.sv -----
// stack memory and the sequencer that runs push, pop, search and clear
module lss_core #(
    parameter int DEPTH = lss_pkg::LSS_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  lss_pkg::kind_t                  kind,
    input  logic signed [lss_pkg::WORD_W-1:0] value_in,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lss_pkg::res_t                   res
);
    import lss_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_EMIT,
        S_SRCH,
        S_SRCH_END
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [WORD_W-1:0]         top_reg, top_next;
    logic [WORD_W-1:0]         key_reg, key_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      pend_vld_reg, pend_vld_next;
    logic [CNT_W-1:0]          pend_pos_reg, pend_pos_next;
    status_t                   emit_stat_reg, emit_stat_next;
    logic [WORD_W-1:0]         emit_val_reg, emit_val_next;

    logic [WORD_W-1:0]         mem [DEPTH];
    logic [WORD_W-1:0]         rd_data_reg;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;

    logic [CNT_W-1:0]          idx_inc;
    logic [CNT_W-1:0]          cnt_dec2;
    logic                      hit;

    assign idx_inc  = idx_reg + 1'b1;
    assign cnt_dec2 = cnt_reg - CNT_W'(2);
    assign hit      = (rd_data_reg == key_reg);

    // single-port stack memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sequencer next state and result selection
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_pos_next  = pend_pos_reg;
        emit_stat_next = emit_stat_reg;
        emit_val_next  = emit_val_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = idx_inc[ADDR_W-1:0];
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        res.status      = emit_stat_reg;
        res.value_out   = emit_val_reg;
        res.position    = '0;
        res.entry_count = POS_W'(cnt_reg);
        res.is_empty    = (cnt_reg == '0);
        res.top_word    = top_reg;
        res.last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    emit_val_next = '0;
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                emit_stat_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                top_next       = value_in;
                                cnt_next       = cnt_reg + 1'b1;
                                emit_stat_next = STAT_OK;
                            end
                            state_next = S_EMIT;
                        end
                        KIND_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                emit_stat_next = STAT_EMPTY;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                // fetch the entry under the top, it becomes the new top
                                emit_stat_next = STAT_OK;
                                emit_val_next  = top_reg;
                                cnt_next       = cnt_reg - 1'b1;
                                rd_en          = 1'b1;
                                rd_addr        = cnt_dec2[ADDR_W-1:0];
                                state_next     = S_POP_RD;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            key_next      = value_in;
                            idx_next      = '0;
                            pend_vld_next = 1'b0;
                            if (cnt_reg == '0)
                            begin
                                emit_stat_next = STAT_NOTFOUND;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SRCH;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cnt_next       = '0;
                            top_next       = '0;
                            emit_stat_next = STAT_OK;
                            state_next     = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                top_next   = (cnt_reg == '0) ? '0 : rd_data_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRCH:
            begin
                // a new hit releases the previous one, which is then not the last
                res.status    = STAT_OK;
                res.value_out = key_reg;
                res.position  = POS_W'(pend_pos_reg);
                res.last      = 1'b0;
                res_valid     = hit && pend_vld_reg;
                if (!(hit && pend_vld_reg && !res_ready))
                begin
                    if (hit)
                    begin
                        pend_vld_next = 1'b1;
                        pend_pos_next = idx_inc;
                    end
                    if (idx_inc == cnt_reg)
                    begin
                        state_next = S_SRCH_END;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            S_SRCH_END:
            begin
                res_valid = 1'b1;
                if (pend_vld_reg)
                begin
                    res.status    = STAT_OK;
                    res.value_out = key_reg;
                    res.position  = POS_W'(pend_pos_reg);
                end
                else
                begin
                    res.status    = STAT_NOTFOUND;
                    res.value_out = '0;
                end
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            top_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            emit_stat_reg <= STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            pend_vld_reg  <= pend_vld_next;
            emit_stat_reg <= emit_stat_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pend_pos_reg <= pend_pos_next;
        emit_val_reg <= emit_val_next;
    end

endmodule

// ----- rtl/lifo_stack_with_search_unit.sv -----
// top level of the lifo stack with linear search
//
// A stack of DEPTH signed 32-bit words behind one single-port memory with a
// registered read. One word is taken at a time and the input is not ready
// until its last result has gone into the output register. Push and clear
// go straight to the result; pop first reads the new top from memory (not
// on an empty stack), and search makes one memory read per stored entry; the
// output side can stall each of them. Search gives one result per match,
// bottom first, or a single not-found result. The memory needs no clearing
// after reset.
`include "assert_macros.svh"

module lifo_stack_with_search_unit #(
    parameter int DEPTH = lss_pkg::LSS_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_in[31:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], value_out[33:2], position[40:34], entry_count[47:41],
    // is_empty[48], top_word[80:49], zero pad[87:81]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import lss_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_vld_reg;
    res_t  out_res_reg;

    // output register is free when empty or being drained
    assign res_ready = !out_vld_reg || m_axis_tready;

    lss_core #(
        .DEPTH(DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .kind     (kind_t'(s_axis_tuser)),
        .value_in (s_axis_tdata),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_res_reg.last;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_res_reg.top_word, out_res_reg.is_empty,
                            out_res_reg.entry_count, out_res_reg.position,
                            out_res_reg.value_out, out_res_reg.status};

    // checks
    `ASSERT_IMPLIES(a_cnt_range, out_vld_reg, out_res_reg.entry_count <= POS_W'(DEPTH), "count above depth")
    `ASSERT_IMPLIES(a_empty_flag, out_vld_reg, out_res_reg.is_empty == (out_res_reg.entry_count == '0), "empty flag disagrees with count")
    `ASSERT_IMPLIES(a_empty_top, out_vld_reg && out_res_reg.is_empty, out_res_reg.top_word == '0, "top word not zero on empty stack")
    `ASSERT_IMPLIES(a_found_pos, out_vld_reg && !out_res_reg.last, out_res_reg.status == STAT_OK && out_res_reg.position != '0, "non-final word is not a search hit")
    `ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

endmodule

// ----- sim/testbench.sv -----
// testbench for the lifo stack with linear search: directed and random words, scoreboard check
`timescale 1ns / 100ps

module testbench;

    import lss_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_WORDS   = 300;

    // stack predictor and store of expected results
    class stack_scoreboard;
        logic signed [WORD_W-1:0] words [LSS_DEPTH];
        int   fill;
        res_t expected_q[$];
        int   errors;
        int   results_seen;
        int   refused_pushes;
        int   empty_pops;
        int   most_matches;
        int   deepest;

        function new();
            fill           = 0;
            errors         = 0;
            results_seen   = 0;
            refused_pushes = 0;
            empty_pops     = 0;
            most_matches   = 0;
            deepest        = 0;
        endfunction

        // queue one result built from the state after the operation
        function void add_result(status_t st, logic signed [WORD_W-1:0] v, int pos, bit lst);
            res_t r;
            r.status      = st;
            r.value_out   = v;
            r.position    = POS_W'(pos);
            r.entry_count = POS_W'(fill);
            r.is_empty    = (fill == 0);
            r.top_word    = (fill == 0) ? '0 : words[fill-1];
            r.last        = lst;
            expected_q.push_back(r);
        endfunction

        // predict the results of one accepted word
        function void note_input(kind_t kind, logic signed [WORD_W-1:0] value);
            int hits;
            logic signed [WORD_W-1:0] popped;
            hits = 0;
            case (kind)
                KIND_PUSH:
                begin
                    if (fill >= LSS_DEPTH)
                    begin
                        refused_pushes++;
                        add_result(STAT_FULL, '0, 0, 1'b1);
                    end
                    else
                    begin
                        words[fill] = value;
                        fill++;
                        if (fill > deepest)
                            deepest = fill;
                        add_result(STAT_OK, '0, 0, 1'b1);
                    end
                end
                KIND_POP:
                begin
                    if (fill == 0)
                    begin
                        empty_pops++;
                        add_result(STAT_EMPTY, '0, 0, 1'b1);
                    end
                    else
                    begin
                        popped = words[fill-1];
                        fill--;
                        add_result(STAT_OK, popped, 0, 1'b1);
                    end
                end
                KIND_SEARCH:
                begin
                    // bottom to top, one result per match
                    for (int i = 0; i < fill; i++)
                    begin
                        if (words[i] == value)
                        begin
                            add_result(STAT_OK, value, i + 1, 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        add_result(STAT_NOTFOUND, '0, 0, 1'b1);
                    else
                        expected_q[expected_q.size()-1].last = 1'b1;
                    if (hits > most_matches)
                        most_matches = hits;
                end
                default:
                begin
                    fill = 0;
                    add_result(STAT_OK, '0, 0, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(logic [87:0] data, logic lst);
            res_t e;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("result word %0h with nothing expected", data);
                return;
            end
            e = expected_q.pop_front();
            check_field("status", e.status, data[1:0]);
            check_field("value_out", e.value_out, data[33:2]);
            check_field("position", e.position, data[40:34]);
            check_field("entry_count", e.entry_count, data[47:41]);
            check_field("is_empty", e.is_empty, data[48]);
            check_field("top_word", e.top_word, data[80:49]);
            check_field("pad", '0, data[87:81]);
            check_field("last", e.last, lst);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    stack_scoreboard sb;
    bit tx_idle_en;
    bit rx_idle_en;
    int words_sent;
    int idle_cycles;
    logic signed [31:0] key_pool [8];

    lifo_stack_with_search_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // keys drawn from a small pool so that searches hit
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) < 60)
            return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // drive one word and wait for the handshake
    task automatic send_word(kind_t kind, logic signed [31:0] value);
        int gap;
        gap = pick_gap(tx_idle_en);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(kind, value);
        words_sent++;
    endtask

    // random mix of all operations
    task automatic run_mixed(int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_word(KIND_PUSH, pick_value());
            else if (r < 65)
                send_word(KIND_POP, pick_value());
            else if (r < 95)
                send_word(KIND_SEARCH, pick_value());
            else
                send_word(KIND_CLEAR, $urandom);
        end
    endtask

    // fill to the top with few distinct keys, overflow, then search
    task automatic run_fill();
        int nkeys;
        logic signed [31:0] keys [3];
        nkeys = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++)
            keys[i] = pick_value();
        while (sb.fill < LSS_DEPTH)
            send_word(KIND_PUSH, keys[$urandom_range(0, nkeys - 1)]);
        repeat ($urandom_range(1, 3))
            send_word(KIND_PUSH, $urandom);
        for (int i = 0; i < nkeys; i++)
            send_word(KIND_SEARCH, keys[i]);
        send_word(KIND_SEARCH, $urandom);
    endtask

    // pop down to empty and one or two past it, then search
    task automatic run_drain();
        while (sb.fill > 0)
            send_word(KIND_POP, $urandom);
        repeat ($urandom_range(1, 2))
            send_word(KIND_POP, $urandom);
        send_word(KIND_SEARCH, pick_value());
    endtask

    // result side: random stalls, check each accepted word
    initial
    begin : sink
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = pick_gap(rx_idle_en);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // reset, directed words, random phases, drain, verdict
    initial
    begin : stimulus
        int phase;
        int random_base;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_PUSH;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        words_sent    = 0;
        idle_cycles   = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            key_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, extreme words, repeated keys, clear
        send_word(KIND_CLEAR, 32'h0);
        send_word(KIND_POP, 32'h0);
        send_word(KIND_SEARCH, 32'h0);
        send_word(KIND_PUSH, 32'h8000_0000);
        send_word(KIND_PUSH, 32'h7fff_ffff);
        send_word(KIND_PUSH, 32'h0000_0000);
        send_word(KIND_PUSH, 32'hffff_ffff);
        send_word(KIND_PUSH, 32'h7fff_ffff);
        send_word(KIND_SEARCH, 32'h7fff_ffff);
        send_word(KIND_SEARCH, 32'h8000_0000);
        send_word(KIND_SEARCH, 32'hffff_ffff);
        send_word(KIND_SEARCH, 32'h1234_5678);
        send_word(KIND_SEARCH, 32'h0000_0000);
        send_word(KIND_POP, 32'h0);
        send_word(KIND_POP, 32'h0);
        send_word(KIND_SEARCH, 32'h7fff_ffff);
        send_word(KIND_CLEAR, 32'hffff_ffff);
        send_word(KIND_POP, 32'h0);
        send_word(KIND_SEARCH, 32'h7fff_ffff);
        send_word(KIND_PUSH, 32'h5a5a_a5a5);
        send_word(KIND_POP, 32'h0);
        send_word(KIND_POP, 32'h0);

        // random phases, idling switched per phase
        random_base = words_sent;
        phase = 0;
        while (words_sent - random_base < RANDOM_WORDS)
        begin
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            case (phase % 4)
                0: run_mixed(40);
                1: run_fill();
                2: run_mixed(30);
                default: run_drain();
            endcase
            phase++;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LSS_DEPTH + 16) @(posedge clk);

        $display("sent %0d words, checked %0d results; %0d pushes refused full, %0d pops on empty",
                 words_sent, sb.results_seen, sb.refused_pushes, sb.empty_pops);
        $display("stack reached %0d entries; largest search gave %0d matches",
                 sb.deepest, sb.most_matches);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lss_pkg.sv
rtl/lss_core.sv
rtl/lifo_stack_with_search_unit.sv
sim/testbench.sv
